// ===== rtl/rv64_instruction_decoder_top_assert.svh =====
// Assertion macros for the decoder's checker file.
`ifndef RV64_INSTRUCTION_DECODER_TOP_ASSERT_SVH
`define RV64_INSTRUCTION_DECODER_TOP_ASSERT_SVH

// Clocked assertion, ignored while reset is applied.
`define RVDEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that is also checked while reset is applied.
`define RVDEC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/rvdec_pkg.sv =====
// Types and constants of the RV64IF instruction decoder.
`default_nettype none

package rvdec_pkg;

  // Format codes as given on the format output
  typedef enum logic [2:0] {
    FMT_ECALL = 3'd0,
    FMT_R     = 3'd1,
    FMT_I     = 3'd2,
    FMT_S     = 3'd3,
    FMT_SB    = 3'd4,
    FMT_U     = 3'd5,
    FMT_UJ    = 3'd6,
    FMT_R4    = 3'd7
  } fmt_e;

  // Major opcodes
  localparam logic [6:0] OPC_LOAD     = 7'h03;
  localparam logic [6:0] OPC_LOAD_FP  = 7'h07;
  localparam logic [6:0] OPC_OP_IMM   = 7'h13;
  localparam logic [6:0] OPC_AUIPC    = 7'h17;
  localparam logic [6:0] OPC_OP_IMM32 = 7'h1B;
  localparam logic [6:0] OPC_STORE    = 7'h23;
  localparam logic [6:0] OPC_STORE_FP = 7'h27;
  localparam logic [6:0] OPC_OP       = 7'h33;
  localparam logic [6:0] OPC_LUI      = 7'h37;
  localparam logic [6:0] OPC_OP32     = 7'h3B;
  localparam logic [6:0] OPC_FMADD    = 7'h43;
  localparam logic [6:0] OPC_FMSUB    = 7'h47;
  localparam logic [6:0] OPC_FNMSUB   = 7'h4B;
  localparam logic [6:0] OPC_FNMADD   = 7'h4F;
  localparam logic [6:0] OPC_OP_FP    = 7'h53;
  localparam logic [6:0] OPC_BRANCH   = 7'h63;
  localparam logic [6:0] OPC_JALR     = 7'h67;
  localparam logic [6:0] OPC_JAL      = 7'h6F;

  // The one system word that is recognized
  localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

  // Operand usage tags per format
  localparam logic [7:0] TAG_ECALL = 8'd0;
  localparam logic [7:0] TAG_R     = 8'd62;
  localparam logic [7:0] TAG_I     = 8'd27;
  localparam logic [7:0] TAG_S     = 8'd51;
  localparam logic [7:0] TAG_SB    = 8'd51;
  localparam logic [7:0] TAG_U     = 8'd9;
  localparam logic [7:0] TAG_UJ    = 8'd9;
  localparam logic [7:0] TAG_R4    = 8'd250;

  // One decoded instruction
  typedef struct packed {
    logic               decode_ok;
    fmt_e               fmt;
    logic        [7:0]  usage_tag;
    logic        [6:0]  opcode_bits;
    logic        [4:0]  dest_reg;
    logic        [4:0]  src1_reg;
    logic        [4:0]  src2_reg;
    logic        [4:0]  src3_reg;
    logic        [2:0]  funct3_bits;
    logic        [6:0]  funct7_bits;
    logic        [1:0]  funct2_bits;
    logic signed [63:0] immediate;
  } dec_res_t;

endpackage

`default_nettype wire

// ===== rtl/rv64_instruction_decoder_top.sv =====
// RV64IF instruction decoder: input register, decode logic, result register.
// Usage:
//   Input channel: instruction_word_i with in_valid_i / in_ready_o. A word is
//   transferred on a rising edge where both are high.
//   Output channel: the decoded fields with out_valid_o / out_ready_i, one
//   result per accepted word, in order.
//   Path: a transferred word waits in the input register, is decoded
//   combinationally and is captured in the result register once that is free.
//   Throughput: one word per cycle while out_ready_i is high; decoding is a
//   single pass of field extraction between the two registers.
//   Stall: while the receiver holds out_ready_i low, the result register
//   keeps its item and the input register can still take one more word;
//   in_ready_o drops only when both registers are full and out_ready_i is low.
//   Reset: rst_ni low empties both registers at once; in_ready_o is high
//   and out_valid_o low right after reset.
`default_nettype none

module rv64_instruction_decoder_top
  import rvdec_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic        [31:0] instruction_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               decode_ok_o,
  output logic        [2:0]  format_o,
  output logic        [7:0]  usage_tag_o,
  output logic        [6:0]  opcode_bits_o,
  output logic        [4:0]  dest_reg_o,
  output logic        [4:0]  src1_reg_o,
  output logic        [4:0]  src2_reg_o,
  output logic        [4:0]  src3_reg_o,
  output logic        [2:0]  funct3_bits_o,
  output logic        [6:0]  funct7_bits_o,
  output logic        [1:0]  funct2_bits_o,
  output logic signed [63:0] immediate_o
);

  logic        in_valid_q;
  logic [31:0] instr_q;
  logic        out_valid_q;
  dec_res_t    res_d;
  dec_res_t    res_q;
  logic        out_free;
  logic        in_free;

  // Stage advance conditions
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_free    = !in_valid_q || out_free;
  assign in_ready_o = in_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_free) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && in_valid_i) begin
      instr_q <= instruction_word_i;
    end
  end

  // Decode
  rvdec_decode u_decode (
    .instr_i (instr_q),
    .res_o   (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && in_valid_q) begin
      res_q <= res_d;
    end
  end

  // Output fields
  assign out_valid_o   = out_valid_q;
  assign decode_ok_o   = res_q.decode_ok;
  assign format_o      = res_q.fmt;
  assign usage_tag_o   = res_q.usage_tag;
  assign opcode_bits_o = res_q.opcode_bits;
  assign dest_reg_o    = res_q.dest_reg;
  assign src1_reg_o    = res_q.src1_reg;
  assign src2_reg_o    = res_q.src2_reg;
  assign src3_reg_o    = res_q.src3_reg;
  assign funct3_bits_o = res_q.funct3_bits;
  assign funct7_bits_o = res_q.funct7_bits;
  assign funct2_bits_o = res_q.funct2_bits;
  assign immediate_o   = res_q.immediate;

endmodule

`default_nettype wire

// ===== rtl/rvdec_decode.sv =====
// Combinational field extraction for one RV64IF instruction word.
`default_nettype none

module rvdec_decode
  import rvdec_pkg::*;
(
  input  logic [31:0] instr_i,
  output dec_res_t    res_o
);

  logic [6:0] opc;
  logic       known;
  fmt_e       fmt;

  assign opc = instr_i[6:0];

  // Opcode classification
  always_comb begin
    known = 1'b1;
    fmt   = FMT_ECALL;
    unique case (opc)
      OPC_OP, OPC_OP32, OPC_OP_FP: begin
        fmt = FMT_R;
      end
      OPC_LOAD, OPC_LOAD_FP, OPC_OP_IMM, OPC_OP_IMM32, OPC_JALR: begin
        fmt = FMT_I;
      end
      OPC_STORE, OPC_STORE_FP: begin
        fmt = FMT_S;
      end
      OPC_BRANCH: begin
        fmt = FMT_SB;
      end
      OPC_AUIPC, OPC_LUI: begin
        fmt = FMT_U;
      end
      OPC_JAL: begin
        fmt = FMT_UJ;
      end
      OPC_FMADD, OPC_FMSUB, OPC_FNMSUB, OPC_FNMADD: begin
        fmt = FMT_R4;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Field selection; fields a format does not use stay zero
  always_comb begin
    res_o = '0;
    if (instr_i == ECALL_WORD) begin
      // environment call: only the ok flag is set
      res_o.decode_ok = 1'b1;
    end else if (known) begin
      res_o.decode_ok   = 1'b1;
      res_o.fmt         = fmt;
      res_o.opcode_bits = opc;
      unique case (fmt)
        FMT_R: begin
          res_o.usage_tag   = TAG_R;
          res_o.funct7_bits = instr_i[31:25];
          res_o.funct3_bits = instr_i[14:12];
          res_o.dest_reg    = instr_i[11:7];
          res_o.src1_reg    = instr_i[19:15];
          res_o.src2_reg    = instr_i[24:20];
        end
        FMT_R4: begin
          res_o.usage_tag   = TAG_R4;
          res_o.funct2_bits = instr_i[26:25];
          res_o.src3_reg    = instr_i[31:27];
          res_o.funct3_bits = instr_i[14:12];
          res_o.dest_reg    = instr_i[11:7];
          res_o.src1_reg    = instr_i[19:15];
          res_o.src2_reg    = instr_i[24:20];
        end
        FMT_I: begin
          res_o.usage_tag   = TAG_I;
          res_o.funct3_bits = instr_i[14:12];
          res_o.dest_reg    = instr_i[11:7];
          res_o.src1_reg    = instr_i[19:15];
          res_o.immediate   = {{52{instr_i[31]}}, instr_i[31:20]};
        end
        FMT_S: begin
          res_o.usage_tag   = TAG_S;
          res_o.funct3_bits = instr_i[14:12];
          res_o.src1_reg    = instr_i[19:15];
          res_o.src2_reg    = instr_i[24:20];
          res_o.immediate   = {{52{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
        end
        FMT_SB: begin
          res_o.usage_tag   = TAG_SB;
          res_o.funct3_bits = instr_i[14:12];
          res_o.src1_reg    = instr_i[19:15];
          res_o.src2_reg    = instr_i[24:20];
          res_o.immediate   = {{52{instr_i[31]}}, instr_i[7], instr_i[30:25],
                               instr_i[11:8], 1'b0};
        end
        FMT_U: begin
          res_o.usage_tag   = TAG_U;
          res_o.dest_reg    = instr_i[11:7];
          res_o.immediate   = {{32{instr_i[31]}}, instr_i[31:12], 12'b0};
        end
        FMT_UJ: begin
          res_o.usage_tag   = TAG_UJ;
          res_o.dest_reg    = instr_i[11:7];
          res_o.immediate   = {{44{instr_i[31]}}, instr_i[19:12], instr_i[20],
                               instr_i[30:21], 1'b0};
        end
        default: begin
          // ecall code is never produced by the opcode table
          res_o.usage_tag   = TAG_ECALL;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rvdec_checker.sv =====
// Port-level checks for the instruction decoder, bound to its top level.
`default_nettype none

`include "rv64_instruction_decoder_top_assert.svh"

module rvdec_checker
  import rvdec_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               decode_ok_o,
  input logic        [2:0]  format_o,
  input logic        [7:0]  usage_tag_o,
  input logic        [6:0]  opcode_bits_o,
  input logic signed [63:0] immediate_o
);

  // Nothing is offered in the cycle after reset is seen
  `RVDEC_ASSERT_RST(a_no_out_in_reset, !rst_ni |=> !out_valid_o,
                    "result valid during reset")

  // An empty result register never blocks the input side
  `RVDEC_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o,
                "input stalled with no result")

  // A stalled result holds
  `RVDEC_ASSERT(a_hold_on_stall,
                out_valid_o && !out_ready_i |=>
                  out_valid_o && $stable(immediate_o) && $stable(format_o),
                "stalled result changed")

  // A decode error carries no format, tag, opcode or immediate
  `RVDEC_ASSERT(a_err_zero,
                out_valid_o && !decode_ok_o |->
                  format_o == FMT_ECALL && usage_tag_o == TAG_ECALL &&
                  opcode_bits_o == 7'd0 && immediate_o == 64'sd0,
                "decode error with nonzero fields")

  // Fused multiply-add results carry their usage tag
  `RVDEC_ASSERT(a_r4_tag,
                out_valid_o && decode_ok_o && format_o == FMT_R4 |->
                  usage_tag_o == TAG_R4,
                "R4 format with wrong usage tag")

endmodule

bind rv64_instruction_decoder_top rvdec_checker u_rvdec_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .decode_ok_o   (decode_ok_o),
  .format_o      (format_o),
  .usage_tag_o   (usage_tag_o),
  .opcode_bits_o (opcode_bits_o),
  .immediate_o   (immediate_o)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the RV64IF instruction decoder, with random traffic and stalls.
`timescale 1ns / 1ps

module testbench;
  import rvdec_pkg::*;

  localparam int DIR_N      = 24;
  localparam int RAND_N     = 930;
  localparam int PAUSE_AT   = 500;
  localparam int IDLE_LIMIT = 1000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic        [31:0] instruction_word_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               decode_ok_o;
  logic        [2:0]  format_o;
  logic        [7:0]  usage_tag_o;
  logic        [6:0]  opcode_bits_o;
  logic        [4:0]  dest_reg_o;
  logic        [4:0]  src1_reg_o;
  logic        [4:0]  src2_reg_o;
  logic        [4:0]  src3_reg_o;
  logic        [2:0]  funct3_bits_o;
  logic        [6:0]  funct7_bits_o;
  logic        [1:0]  funct2_bits_o;
  logic signed [63:0] immediate_o;

  rv64_instruction_decoder_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .instruction_word_i (instruction_word_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .decode_ok_o        (decode_ok_o),
    .format_o           (format_o),
    .usage_tag_o        (usage_tag_o),
    .opcode_bits_o      (opcode_bits_o),
    .dest_reg_o         (dest_reg_o),
    .src1_reg_o         (src1_reg_o),
    .src2_reg_o         (src2_reg_o),
    .src3_reg_o         (src3_reg_o),
    .funct3_bits_o      (funct3_bits_o),
    .funct7_bits_o      (funct7_bits_o),
    .funct2_bits_o      (funct2_bits_o),
    .immediate_o        (immediate_o)
  );

  // Decoded results still owed by the block, oldest first
  dec_res_t pending_decodes[$];

  int words_sent;
  int results_seen;
  int mismatches;
  bit calm;        // no idling on either side while set
  int rx_hold;
  int rx_gap;

  // Directed stimulus table
  logic [31:0] dir_word  [DIR_N];
  bit          dir_fixed [DIR_N];
  dec_res_t    dir_want  [DIR_N];

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Decode one instruction word the way the block should
  function automatic dec_res_t decode_word(logic [31:0] w);
    dec_res_t res;
    res = '0;
    if (w == ECALL_WORD) begin
      res.decode_ok = 1'b1;
    end else begin
      res.decode_ok   = 1'b1;
      res.opcode_bits = w[6:0];
      case (w[6:0])
        OPC_OP, OPC_OP32, OPC_OP_FP: begin
          res.fmt         = FMT_R;
          res.usage_tag   = TAG_R;
          res.funct7_bits = w[31:25];
          res.funct3_bits = w[14:12];
          res.dest_reg    = w[11:7];
          res.src1_reg    = w[19:15];
          res.src2_reg    = w[24:20];
        end
        OPC_FMADD, OPC_FMSUB, OPC_FNMSUB, OPC_FNMADD: begin
          res.fmt         = FMT_R4;
          res.usage_tag   = TAG_R4;
          res.funct2_bits = w[26:25];
          res.src3_reg    = w[31:27];
          res.funct3_bits = w[14:12];
          res.dest_reg    = w[11:7];
          res.src1_reg    = w[19:15];
          res.src2_reg    = w[24:20];
        end
        OPC_LOAD, OPC_LOAD_FP, OPC_OP_IMM, OPC_OP_IMM32, OPC_JALR: begin
          // shift amounts stay inside the immediate, funct bits and all
          res.fmt         = FMT_I;
          res.usage_tag   = TAG_I;
          res.funct3_bits = w[14:12];
          res.dest_reg    = w[11:7];
          res.src1_reg    = w[19:15];
          res.immediate   = {{52{w[31]}}, w[31:20]};
        end
        OPC_STORE, OPC_STORE_FP: begin
          res.fmt         = FMT_S;
          res.usage_tag   = TAG_S;
          res.funct3_bits = w[14:12];
          res.src1_reg    = w[19:15];
          res.src2_reg    = w[24:20];
          res.immediate   = {{52{w[31]}}, w[31:25], w[11:7]};
        end
        OPC_BRANCH: begin
          res.fmt         = FMT_SB;
          res.usage_tag   = TAG_SB;
          res.funct3_bits = w[14:12];
          res.src1_reg    = w[19:15];
          res.src2_reg    = w[24:20];
          res.immediate   = {{52{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
        end
        OPC_AUIPC, OPC_LUI: begin
          res.fmt         = FMT_U;
          res.usage_tag   = TAG_U;
          res.dest_reg    = w[11:7];
          res.immediate   = {{32{w[31]}}, w[31:12], 12'b0};
        end
        OPC_JAL: begin
          res.fmt         = FMT_UJ;
          res.usage_tag   = TAG_UJ;
          res.dest_reg    = w[11:7];
          res.immediate   = {{44{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
        end
        default: begin
          // unknown opcode, including system words other than ecall
          res = '0;
        end
      endcase
    end
    return res;
  endfunction

  // One of the 18 recognized major opcodes
  function automatic logic [6:0] opc_by_index(int idx);
    case (idx)
      0:       return OPC_LOAD;
      1:       return OPC_LOAD_FP;
      2:       return OPC_OP_IMM;
      3:       return OPC_AUIPC;
      4:       return OPC_OP_IMM32;
      5:       return OPC_STORE;
      6:       return OPC_STORE_FP;
      7:       return OPC_OP;
      8:       return OPC_LUI;
      9:       return OPC_OP32;
      10:      return OPC_FMADD;
      11:      return OPC_FMSUB;
      12:      return OPC_FNMSUB;
      13:      return OPC_FNMADD;
      14:      return OPC_OP_FP;
      15:      return OPC_BRANCH;
      16:      return OPC_JALR;
      default: return OPC_JAL;
    endcase
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Mostly real instructions with random fields, plus system words and noise
  function automatic logic [31:0] gen_word();
    int          r;
    logic [31:0] raw;
    r   = $urandom_range(0, 99);
    raw = $urandom();
    if (r < 80) return {raw[31:7], opc_by_index($urandom_range(0, 17))};
    if (r < 84) return ECALL_WORD;
    if (r < 90) return {raw[31:7], 7'h73};
    return raw;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Present one word after a gap and hold it until the transfer.
  // Entered and left just after a falling edge.
  task automatic send_word(logic [31:0] word, dec_res_t want, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    instruction_word_i <= word;
    do @(posedge clk_i); while (!in_ready_o);
    pending_decodes.push_back(want);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Hold off the sender until every owed result has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_decodes.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // Receiver: ready runs and stalls of random length
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (calm) begin
        out_ready_i <= 1'b1;
        rx_hold = 0;
      end else if (rx_hold > 0) begin
        rx_hold--;
      end else begin
        rx_gap = pick_gap();
        if (rx_gap == 0) begin
          out_ready_i <= 1'b1;
          rx_hold = $urandom_range(0, 7);
        end else begin
          out_ready_i <= 1'b0;
          rx_hold = rx_gap - 1;
        end
      end
    end
  end

  // Result checker: each output transfer against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_decodes.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual opcode %h format %0d",
                 $time, opcode_bits_o, format_o);
        mismatches++;
      end else begin
        dec_res_t want;
        want = pending_decodes.pop_front();
        results_seen++;
        check_field("decode_ok", want.decode_ok, decode_ok_o);
        check_field("format", want.fmt, format_o);
        check_field("usage_tag", want.usage_tag, usage_tag_o);
        check_field("opcode_bits", want.opcode_bits, opcode_bits_o);
        check_field("dest_reg", want.dest_reg, dest_reg_o);
        check_field("src1_reg", want.src1_reg, src1_reg_o);
        check_field("src2_reg", want.src2_reg, src2_reg_o);
        check_field("src3_reg", want.src3_reg, src3_reg_o);
        check_field("funct3_bits", want.funct3_bits, funct3_bits_o);
        check_field("funct7_bits", want.funct7_bits, funct7_bits_o);
        check_field("funct2_bits", want.funct2_bits, funct2_bits_o);
        check_field("immediate", want.immediate, immediate_o);
      end
    end
  end

  // Watchdog: too many cycles without any transfer ends the run
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Main sequence
  initial begin
    logic [31:0] word;
    dec_res_t    want;

    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    instruction_word_i = '0;
    out_ready_i        = 1'b0;
    calm               = 1'b0;
    rx_hold            = 0;
    words_sent         = 0;
    results_seen       = 0;
    mismatches         = 0;

    // Every major opcode with alternating field bits
    for (int i = 0; i < 18; i++) begin
      dir_word[i]  = {(i % 2 == 0) ? 25'h155_5555 : 25'h0AA_AAAA, opc_by_index(i)};
      dir_fixed[i] = 1'b0;
      dir_want[i]  = '0;
    end
    // Environment call
    dir_word[18]  = ECALL_WORD;
    dir_fixed[18] = 1'b1;
    dir_want[18]  = '0;
    dir_want[18].decode_ok = 1'b1;
    // System word that is not ecall, all zeros, all ones: all rejected
    dir_word[19]  = 32'h0010_0073;
    dir_fixed[19] = 1'b1;
    dir_want[19]  = '0;
    dir_word[20]  = 32'h0000_0000;
    dir_fixed[20] = 1'b1;
    dir_want[20]  = '0;
    dir_word[21]  = 32'hFFFF_FFFF;
    dir_fixed[21] = 1'b1;
    dir_want[21]  = '0;
    // I format with every field at its maximum
    dir_word[22]  = 32'hFFFF_FF93;
    dir_fixed[22] = 1'b1;
    dir_want[22]  = '0;
    dir_want[22].decode_ok   = 1'b1;
    dir_want[22].fmt         = FMT_I;
    dir_want[22].usage_tag   = TAG_I;
    dir_want[22].opcode_bits = OPC_OP_IMM;
    dir_want[22].dest_reg    = 5'd31;
    dir_want[22].src1_reg    = 5'd31;
    dir_want[22].funct3_bits = 3'd7;
    dir_want[22].immediate   = -64'sd1;
    // Arithmetic shift right: funct bits stay in the immediate
    dir_word[23]  = 32'h4030_D093;
    dir_fixed[23] = 1'b0;
    dir_want[23]  = '0;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    if (out_valid_o !== 1'b0 || in_ready_o !== 1'b1) begin
      $display("%0t ns: after reset expected out_valid 0 in_ready 1, actual %b %b",
               $time, out_valid_o, in_ready_o);
      mismatches++;
    end

    // Directed part
    for (int i = 0; i < DIR_N; i++) begin
      want = dir_fixed[i] ? dir_want[i] : decode_word(dir_word[i]);
      send_word(dir_word[i], want, pick_gap());
    end
    drain_results();

    // Random part, with two stretches of back-to-back traffic
    for (int k = 0; k < RAND_N; k++) begin
      if (k == PAUSE_AT) drain_results();
      calm = (k >= 200 && k < 300) || (k >= 700 && k < 760);
      word = gen_word();
      send_word(word, decode_word(word), calm ? 0 : pick_gap());
    end
    calm = 1'b0;

    drain_results();
    repeat (4) @(negedge clk_i);

    $display("Sent %0d instruction words (%0d directed, %0d random) over all formats,",
             words_sent, DIR_N, RAND_N);
    $display("ecall and rejected opcodes; %0d results checked, %0d mismatches.",
             results_seen, mismatches);
    if (mismatches == 0 && pending_decodes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rvdec_pkg.sv
rtl/rvdec_decode.sv
rtl/rv64_instruction_decoder_top.sv
rtl/rvdec_checker.sv
bench/testbench.sv
